[hw/rtl/hav_pkg.sv]
// Shared constants and arithmetic helpers for the haversine distance pipeline.
package hav_pkg;

    // Default number of CORDIC iterations
    localparam int CORDIC_STAGES_DEF = 32;

    // Width of a reduced angle in 2^-24 degree units, and of the CORDIC datapath
    localparam int AW = 34;
    localparam int CW = 34;

    // Square root unit: root bits and radicand width
    localparam int ROOT_W = 31;
    localparam int REM_W  = 61;

    // CORDIC rotation gain, Q30
    localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;

    // Angle reduction constants, 2^-24 degree units
    localparam logic signed [35:0] TURN_U24  = 36'sd6039797760;
    localparam logic signed [35:0] HALF_U24  = 36'sd3019898880;
    localparam logic signed [35:0] QUART_U24 = 36'sd1509949440;

    // Degree to radian scaling: pi * 2^31 split into two partial factors
    localparam logic [32:0] PI_Q31 = 33'd6746518852;
    localparam logic [15:0] PI_HI  = PI_Q31[32:17];
    localparam logic [16:0] PI_LO  = PI_Q31[16:0];

    // Half of the divisor 180 * 2^25, for rounding
    localparam logic [63:0] RAD_HALF = 64'd3019898880;

    // Divide by 45: multiply by ceil(2^30 / 45), exact for inputs below 2^25
    localparam logic [24:0] RECIP_45 = 25'd23860930;
    localparam logic [5:0]  DIV_45   = 6'd45;

    localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
    localparam logic [33:0] DIST_MAX   = 34'h3_FFFF_FFFF;
    localparam logic [23:0] RADIUS_RST = 24'd6371000;

    // Arctangent of 2^-stage in Q30
    function automatic logic [30:0] atan_q30(input int stage);
        logic [30:0] val;
        case (stage)
            0:  val = 31'd843314856;
            1:  val = 31'd497837829;
            2:  val = 31'd263043836;
            3:  val = 31'd133525158;
            4:  val = 31'd67021686;
            5:  val = 31'd33543515;
            6:  val = 31'd16775850;
            7:  val = 31'd8388437;
            8:  val = 31'd4194282;
            9:  val = 31'd2097149;
            10: val = 31'd1048575;
            default:
            begin
                if (stage >= 11 && stage <= 30)
                    val = 31'((64'd1 << (30 - stage)) - 64'd1);
                else
                    val = '0;
            end
        endcase
        return val;
    endfunction

    // Q30 product of two magnitudes, rounded half up
    function automatic logic [33:0] mul_rnd(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] prod;
        prod = 64'(a) * 64'(b) + 64'h2000_0000;
        return prod[63:30];
    endfunction

endpackage

[hw/rtl/hav_rad_conv.sv]
// Angle reduction and degree to Q30 radian conversion, seven register stages.
module hav_rad_conv (
    input  logic                            clk,
    input  logic                            en,
    input  logic signed [hav_pkg::AW-1:0]   ang,
    output logic signed [hav_pkg::CW-1:0]   z,
    output logic                            neg
);

    localparam int CW = hav_pkg::CW;

    logic signed [35:0] ang_ext;
    logic signed [35:0] wrap_next;
    logic signed [32:0] wrap_reg;
    logic signed [35:0] fold_v;
    logic               fold_neg;
    logic [35:0]        mag_v;
    logic [30:0]        mag_reg;
    logic [1:0]         flag_reg [5];
    logic [46:0]        phi_reg;
    logic [47:0]        plo_reg;
    logic [63:0]        sum_v;
    logic [36:0]        m_reg;
    logic [43:0]        q1_prod;
    logic [13:0]        q1_reg;
    logic [18:0]        mh_reg;
    logic [17:0]        ml_reg;
    logic [18:0]        r1_v;
    logic [23:0]        t_reg;
    logic [13:0]        q1b_reg;
    logic [48:0]        q2_prod;
    logic [31:0]        rad_v;
    logic signed [CW-1:0] rad_s;
    logic signed [CW-1:0] z_reg;
    logic               neg_reg;

    // wrap into [-180, 180)
    always_comb
    begin
        ang_ext = 36'(ang);
        if (ang_ext >= hav_pkg::HALF_U24)
            wrap_next = ang_ext - hav_pkg::TURN_U24;
        else if (ang_ext < -hav_pkg::HALF_U24)
            wrap_next = ang_ext + hav_pkg::TURN_U24;
        else
            wrap_next = ang_ext;
    end

    // fold into [-90, 90], sine and cosine change sign
    always_comb
    begin
        fold_v   = 36'(wrap_reg);
        fold_neg = 1'b0;
        if (fold_v > hav_pkg::QUART_U24)
        begin
            fold_v   = fold_v - hav_pkg::HALF_U24;
            fold_neg = 1'b1;
        end
        else if (fold_v < -hav_pkg::QUART_U24)
        begin
            fold_v   = fold_v + hav_pkg::HALF_U24;
            fold_neg = 1'b1;
        end
        mag_v = fold_v[35] ? 36'(-fold_v) : 36'(fold_v);
    end

    // scale, then divide by 180 * 2^25 as a shift and a divide by 45
    always_comb
    begin
        sum_v   = (64'(phi_reg) << 17) + 64'(plo_reg) + hav_pkg::RAD_HALF;
        q1_prod = 44'(m_reg[36:18]) * 44'(hav_pkg::RECIP_45);
        r1_v    = mh_reg - 19'(q1_reg) * 19'(hav_pkg::DIV_45);
        q2_prod = 49'(t_reg) * 49'(hav_pkg::RECIP_45);
        rad_v   = {q1b_reg, q2_prod[47:30]};
        rad_s   = $signed({2'b00, rad_v});
    end

    // pipeline registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wrap_reg    <= 33'(wrap_next);
            mag_reg     <= mag_v[30:0];
            flag_reg[0] <= {fold_neg, fold_v[35]};
            for (int i = 1; i < 5; i++)
                flag_reg[i] <= flag_reg[i-1];
            phi_reg     <= 47'(mag_reg) * 47'(hav_pkg::PI_HI);
            plo_reg     <= 48'(mag_reg) * 48'(hav_pkg::PI_LO);
            m_reg       <= sum_v[63:27];
            q1_reg      <= q1_prod[43:30];
            mh_reg      <= m_reg[36:18];
            ml_reg      <= m_reg[17:0];
            t_reg       <= {r1_v[5:0], ml_reg};
            q1b_reg     <= q1_reg;
            z_reg       <= flag_reg[4][0] ? -rad_s : rad_s;
            neg_reg     <= flag_reg[4][1];
        end
    end

    assign z   = z_reg;
    assign neg = neg_reg;

endmodule

[hw/rtl/hav_cordic_cell.sv]
// One CORDIC iteration with its own output register.
module hav_cordic_cell #(
    parameter int STAGE  = 0,
    parameter bit VECTOR = 1'b0
) (
    input  logic                            clk,
    input  logic                            en,
    input  logic signed [hav_pkg::CW-1:0]   x_in,
    input  logic signed [hav_pkg::CW-1:0]   y_in,
    input  logic signed [hav_pkg::CW-1:0]   z_in,
    output logic signed [hav_pkg::CW-1:0]   x_out,
    output logic signed [hav_pkg::CW-1:0]   y_out,
    output logic signed [hav_pkg::CW-1:0]   z_out
);

    localparam int CW = hav_pkg::CW;
    localparam logic signed [CW-1:0] ATAN = $signed(CW'(hav_pkg::atan_q30(STAGE)));

    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic                 grow;
    logic signed [CW-1:0] x_next;
    logic signed [CW-1:0] y_next;
    logic signed [CW-1:0] z_next;
    logic signed [CW-1:0] x_reg;
    logic signed [CW-1:0] y_reg;
    logic signed [CW-1:0] z_reg;

    // vectoring drives y to zero, rotation drives z to zero
    always_comb
    begin
        dx   = y_in >>> STAGE;
        dy   = x_in >>> STAGE;
        grow = VECTOR ? ~y_in[CW-1] : z_in[CW-1];
        if (grow)
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ATAN;
        end
        else
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ATAN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

[hw/rtl/hav_sqrt_cell.sv]
// One result bit of a restoring integer square root, registered.
module hav_sqrt_cell #(
    parameter int BIT = 0
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic [hav_pkg::REM_W-1:0]    rem_in,
    input  logic [hav_pkg::ROOT_W-1:0]   root_in,
    output logic [hav_pkg::REM_W-1:0]    rem_out,
    output logic [hav_pkg::ROOT_W-1:0]   root_out
);

    localparam int RW = hav_pkg::REM_W;
    localparam int QW = hav_pkg::ROOT_W;
    localparam int TW = RW + 2;

    logic [TW-1:0] trial;
    logic          take;
    logic [RW-1:0] rem_next;
    logic [QW-1:0] root_next;
    logic [RW-1:0] rem_reg;
    logic [QW-1:0] root_reg;

    // trial = 2*root*2^BIT + 4^BIT, subtract if it fits in the remainder
    always_comb
    begin
        trial     = (TW'(root_in) << (BIT + 1)) | (TW'(1) << (2 * BIT));
        take      = TW'(rem_in) >= trial;
        rem_next  = take ? rem_in - trial[RW-1:0] : rem_in;
        root_next = take ? root_in | (QW'(1) << BIT) : root_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

[hw/rtl/haversine_distance.sv]
// Top level of the pipelined haversine great circle distance unit.
//
// Input stream (s_*): one beat carries two points, latitude and longitude in
// signed degrees times 2^23. Output stream (m_*): one beat per input beat with
// the great circle distance in 1/512 metre, saturated to 34 bits.
// cfg_we / cfg_wdata load the sphere radius in whole metres; write it only
// while no beat is in flight. Reset sets the radius to 6371000.
//
// Throughput: one beat per cycle while m_tready does not hold the pipeline. From
// accept to m_tvalid a beat passes the input register, the degree to radian stages
// (7), the rotation CORDIC row, four multiply stages, a 31 cell square root
// row, the vectoring CORDIC row, the radius multiply and the output register.
//
// When m_tready is low the finished beat waits in the output register; the
// pipeline keeps moving and taking beats until a result reaches its last
// stage, then the whole pipeline holds and s_tready drops.
// Reset empties the pipeline and the output register.
module haversine_distance #(
    parameter int CORDIC_STAGES = hav_pkg::CORDIC_STAGES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    // lat_a [30:0], lon_a [62:31], lat_b [93:63], lon_b [125:94], zero pad
    input  logic [127:0]  s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // distance [33:0], zero pad
    output logic [39:0]   m_tdata,
    input  logic          cfg_we,
    input  logic [23:0]   cfg_wdata
);

    localparam int N     = CORDIC_STAGES;
    localparam int AW    = hav_pkg::AW;
    localparam int CW    = hav_pkg::CW;
    localparam int SQ    = hav_pkg::ROOT_W;
    localparam int RW    = hav_pkg::REM_W;
    localparam int P_SQ  = 12 + N;
    localparam int P_VEC = P_SQ + SQ;
    localparam int DEPTH = P_VEC + N + 1;

    logic               adv;
    logic               v_last;
    logic [DEPTH-1:0]   valid_reg;
    logic [23:0]        radius_reg;

    logic signed [30:0] lat_a;
    logic signed [31:0] lon_a;
    logic signed [30:0] lat_b;
    logic signed [31:0] lon_b;
    logic signed [AW-1:0] ang_reg [4];

    logic signed [CW-1:0] conv_z [4];
    logic                 conv_neg [4];
    logic signed [CW-1:0] sc_x [4][N+1];
    logic signed [CW-1:0] sc_y [4][N+1];
    logic signed [CW-1:0] sc_z [4][N+1];
    logic [1:0]           nl_reg [N];

    logic signed [CW-1:0] ca_s;
    logic signed [CW-1:0] cb_s;
    logic [31:0]          msl_reg;
    logic [31:0]          msn_reg;
    logic [31:0]          mca_reg;
    logic [31:0]          mcb_reg;
    logic                 ccneg0_reg;
    logic [33:0]          sl2_reg;
    logic [33:0]          sn2_reg;
    logic [33:0]          cc_reg;
    logic                 ccneg1_reg;
    logic [33:0]          sl2b_reg;
    logic [33:0]          tm_reg;
    logic                 tneg_reg;
    logic signed [35:0]   a_sum;
    logic [30:0]          a_next;
    logic [30:0]          a_reg;

    logic [RW-1:0]        sq_rem  [2][SQ+1];
    logic [SQ-1:0]        sq_root [2][SQ+1];

    logic signed [CW-1:0] vc_x [N+1];
    logic signed [CW-1:0] vc_y [N+1];
    logic signed [CW-1:0] vc_z [N+1];

    logic [31:0]          cang;
    logic [55:0]          prod_reg;
    logic [56:0]          rnd_sum;
    logic [33:0]          dist_next;
    logic [33:0]          dist_reg;
    logic                 out_valid_reg;

    // pipeline moves unless a finished beat meets a full, stalled output
    assign v_last   = valid_reg[DEPTH-1];
    assign adv      = !v_last || !out_valid_reg || m_tready;
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[DEPTH-2:0], s_tvalid};
    end

    // radius register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radius_reg <= hav_pkg::RADIUS_RST;
        else if (cfg_we)
            radius_reg <= cfg_wdata;
    end

    // input stage: angle differences and doubled latitudes, 2^-24 degree units
    assign lat_a = s_tdata[30:0];
    assign lon_a = s_tdata[62:31];
    assign lat_b = s_tdata[93:63];
    assign lon_b = s_tdata[125:94];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ang_reg[0] <= AW'(lat_b) - AW'(lat_a);
            ang_reg[1] <= AW'(lon_b) - AW'(lon_a);
            ang_reg[2] <= AW'(lat_a) + AW'(lat_a);
            ang_reg[3] <= AW'(lat_b) + AW'(lat_b);
        end
    end

    // four lanes: radians, then a row of rotation cells
    genvar l, j;
    generate
        for (l = 0; l < 4; l++)
        begin : g_lane
            hav_rad_conv u_conv (
                .clk (clk),
                .en  (adv),
                .ang (ang_reg[l]),
                .z   (conv_z[l]),
                .neg (conv_neg[l])
            );

            assign sc_x[l][0] = hav_pkg::GAIN_Q30;
            assign sc_y[l][0] = '0;
            assign sc_z[l][0] = conv_z[l];

            for (j = 0; j < N; j++)
            begin : g_rot
                hav_cordic_cell #(
                    .STAGE  (j),
                    .VECTOR (1'b0)
                ) u_cell (
                    .clk   (clk),
                    .en    (adv),
                    .x_in  (sc_x[l][j]),
                    .y_in  (sc_y[l][j]),
                    .z_in  (sc_z[l][j]),
                    .x_out (sc_x[l][j+1]),
                    .y_out (sc_y[l][j+1]),
                    .z_out (sc_z[l][j+1])
                );
            end
        end
    endgenerate

    // fold sign of the two cosine lanes, delayed alongside the rotation row
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nl_reg[0] <= {conv_neg[3], conv_neg[2]};
            for (int i = 1; i < N; i++)
                nl_reg[i] <= nl_reg[i-1];
        end
    end

    // haversine term: magnitudes, products, combine, clamp
    always_comb
    begin
        ca_s  = nl_reg[N-1][0] ? -sc_x[2][N] : sc_x[2][N];
        cb_s  = nl_reg[N-1][1] ? -sc_x[3][N] : sc_x[3][N];
        a_sum = $signed({2'b00, sl2b_reg})
              + (tneg_reg ? -$signed({2'b00, tm_reg}) : $signed({2'b00, tm_reg}));
        if (a_sum[35])
            a_next = '0;
        else if (a_sum > 36'(hav_pkg::ONE_Q30))
            a_next = hav_pkg::ONE_Q30;
        else
            a_next = a_sum[30:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            msl_reg    <= 32'(sc_y[0][N][CW-1] ? -sc_y[0][N] : sc_y[0][N]);
            msn_reg    <= 32'(sc_y[1][N][CW-1] ? -sc_y[1][N] : sc_y[1][N]);
            mca_reg    <= 32'(ca_s[CW-1] ? -ca_s : ca_s);
            mcb_reg    <= 32'(cb_s[CW-1] ? -cb_s : cb_s);
            ccneg0_reg <= ca_s[CW-1] ^ cb_s[CW-1];
            sl2_reg    <= hav_pkg::mul_rnd(msl_reg, msl_reg);
            sn2_reg    <= hav_pkg::mul_rnd(msn_reg, msn_reg);
            cc_reg     <= hav_pkg::mul_rnd(mca_reg, mcb_reg);
            ccneg1_reg <= ccneg0_reg;
            sl2b_reg   <= sl2_reg;
            tm_reg     <= hav_pkg::mul_rnd(cc_reg[31:0], sn2_reg[31:0]);
            tneg_reg   <= ccneg1_reg;
            a_reg      <= a_next;
        end
    end

    // square roots of a and 1 - a, both scaled by 2^30
    assign sq_rem[0][0]  = {a_reg, 30'b0};
    assign sq_rem[1][0]  = {hav_pkg::ONE_Q30 - a_reg, 30'b0};
    assign sq_root[0][0] = '0;
    assign sq_root[1][0] = '0;

    generate
        for (l = 0; l < 2; l++)
        begin : g_sqrt
            for (j = 0; j < SQ; j++)
            begin : g_bit
                hav_sqrt_cell #(
                    .BIT (SQ - 1 - j)
                ) u_cell (
                    .clk      (clk),
                    .en       (adv),
                    .rem_in   (sq_rem[l][j]),
                    .root_in  (sq_root[l][j]),
                    .rem_out  (sq_rem[l][j+1]),
                    .root_out (sq_root[l][j+1])
                );
            end
        end
    endgenerate

    // central angle: vectoring row on (sqrt(1-a), sqrt(a))
    assign vc_x[0] = $signed(CW'(sq_root[1][SQ]));
    assign vc_y[0] = $signed(CW'(sq_root[0][SQ]));
    assign vc_z[0] = '0;

    generate
        for (j = 0; j < N; j++)
        begin : g_vec
            hav_cordic_cell #(
                .STAGE  (j),
                .VECTOR (1'b1)
            ) u_cell (
                .clk   (clk),
                .en    (adv),
                .x_in  (vc_x[j]),
                .y_in  (vc_y[j]),
                .z_in  (vc_z[j]),
                .x_out (vc_x[j+1]),
                .y_out (vc_y[j+1]),
                .z_out (vc_z[j+1])
            );
        end
    endgenerate

    // double the angle, clamp negative residue, scale by radius
    assign cang = vc_z[N][CW-1] ? '0 : {vc_z[N][30:0], 1'b0};

    always_ff @(posedge clk)
    begin
        if (adv)
            prod_reg <= 56'(radius_reg) * 56'(cang);
    end

    // round to 1/512 metre and saturate
    always_comb
    begin
        rnd_sum   = 57'(prod_reg) + 57'(1 << 20);
        dist_next = (rnd_sum[56:21] > 36'(hav_pkg::DIST_MAX)) ? hav_pkg::DIST_MAX
                                                             : rnd_sum[54:21];
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv && v_last)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv && v_last)
            dist_reg <= dist_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, dist_reg};

    // haversine term stays within [0, 1] after the clamp
    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[P_SQ-1] |-> (a_reg <= hav_pkg::ONE_Q30))
        else $error("haversine term above one");

    // square root row leaves a remainder of at most twice the root
    sqrt_rem: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[P_VEC-1] |-> (sq_rem[0][SQ] <= RW'({sq_root[0][SQ], 1'b0})))
        else $error("square root remainder too large");

    // a beat leaving the last stage lands in the output register
    out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && v_last) |=> out_valid_reg)
        else $error("finished beat not loaded");

    // an accepted beat enters the first stage
    in_load: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> valid_reg[0])
        else $error("accepted beat not captured");

endmodule
